// File: hdl/tfv_pkg.sv
// Shared types, constants and helpers of the typed field text validator.
package tfv_pkg;

  // Field widths
  localparam int LENGTH_BITS = 16;
  localparam int CH_W        = 8;
  localparam int FUNC_W      = 2;
  localparam int MAXLEN_W    = 16;
  localparam int MAG_W       = 32;
  localparam int MAG_EXT_W   = MAG_W + 4;
  localparam int CMP_W       = (LENGTH_BITS > MAXLEN_W) ? LENGTH_BITS : MAXLEN_W;

  // Saturation value of the character counter
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  // Signed 32-bit magnitude limits
  localparam logic [MAG_EXT_W-1:0] INT_POS_LIM = MAG_EXT_W'(64'd2147483647);
  localparam logic [MAG_EXT_W-1:0] INT_NEG_LIM = MAG_EXT_W'(64'd2147483648);

  // Character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

  // Column types
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INT    = 2'd0,
    FUNC_FLOAT  = 2'd1,
    FUNC_STRING = 2'd2,
    FUNC_BOOL   = 2'd3
  } func_t;

  // One registered request
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    func_t               func;
    logic [MAXLEN_W-1:0] max_length;
    logic                is_empty;
    logic                last;
  } item_t;

  // Handshake status of the input stage towards the rest of the pipe
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Expected character of "true" at a position
  function automatic logic [CH_W-1:0] true_char(input logic [1:0] pos);
    logic [CH_W-1:0] c;
    unique case (pos)
      2'd0: c = 8'h74;
      2'd1: c = 8'h72;
      2'd2: c = 8'h75;
      2'd3: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Expected character of "false" at a position; codes past the word never match
  function automatic logic [CH_W-1:0] false_char(input logic [2:0] pos);
    logic [CH_W-1:0] c;
    unique case (pos)
      3'd0: c = 8'h66;
      3'd1: c = 8'h61;
      3'd2: c = 8'h6C;
      3'd3: c = 8'h73;
      3'd4: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/tfv_if.sv
// Valid/ready channel interfaces for character requests and verdicts.
interface tfv_in_if;
  logic                          valid;
  logic                          ready;
  logic [tfv_pkg::CH_W-1:0]      ch;
  logic [tfv_pkg::FUNC_W-1:0]    func;
  logic [tfv_pkg::MAXLEN_W-1:0]  max_length;
  logic                          is_empty;
  logic                          last;

  modport source (output valid, ch, func, max_length, is_empty, last, input ready);
  modport sink   (input valid, ch, func, max_length, is_empty, last, output ready);
endinterface

interface tfv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, valid_res, input ready);
  modport sink   (input valid, valid_res, output ready);
endinterface

// File: hdl/tfv_in_reg.sv
// Input register stage: captures one character request per cycle while the stage is empty or drains.
module tfv_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  tfv_in_if.sink           in_chan,
  input  logic             advance,
  output tfv_pkg::stage_t  stage
);

  logic            valid_r;
  tfv_pkg::item_t  item_r;
  logic            take;

  // Accept whenever the stage is empty or drains this cycle
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.ch         <= in_chan.ch;
      item_r.func       <= tfv_pkg::func_t'(in_chan.func);
      item_r.max_length <= in_chan.max_length;
      item_r.is_empty   <= in_chan.is_empty;
      item_r.last       <= in_chan.last;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// File: hdl/tfv_core.sv
// Field state and per-character check logic, with the verdict on the last request.
module tfv_core (
  input  logic            clk,
  input  logic            rst_n,
  input  tfv_pkg::item_t  item,
  input  logic            fire,
  output logic            verdict
);

  logic [tfv_pkg::LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [tfv_pkg::MAG_W-1:0]       mag_r, mag_nxt;
  logic                            neg_r, neg_nxt;
  logic                            fail_r, fail_nxt;
  logic                            dot_r, dot_nxt;
  logic                            dig_r, dig_nxt;
  logic                            mt_r, mt_nxt;
  logic                            mf_r, mf_nxt;

  logic                             at_start;
  logic                             is_digit;
  logic                             is_sign;
  logic [tfv_pkg::MAG_EXT_W-1:0]    mag_sum;
  logic [tfv_pkg::MAG_EXT_W-1:0]    mag_lim;

  // Classify the character
  assign at_start = (cnt_r == '0);
  assign is_digit = (item.ch >= tfv_pkg::CH_ZERO) && (item.ch <= tfv_pkg::CH_NINE);
  assign is_sign  = at_start && ((item.ch == tfv_pkg::CH_MINUS) ||
                                 (item.ch == tfv_pkg::CH_PLUS));

  // Multiply by ten as two shifts, then add the digit
  assign mag_sum = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} +
                   {{(tfv_pkg::MAG_EXT_W-4){1'b0}}, item.ch[3:0]};
  assign mag_lim = neg_nxt ? tfv_pkg::INT_NEG_LIM : tfv_pkg::INT_POS_LIM;

  // Sign tracking ahead of the type checks
  always_comb begin
    neg_nxt = neg_r;
    if (!item.is_empty && at_start && (item.ch == tfv_pkg::CH_MINUS)) begin
      neg_nxt = 1'b1;
    end
  end

  // Fold the character into the field state
  always_comb begin
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    fail_nxt = fail_r;
    dot_nxt  = dot_r;
    dig_nxt  = dig_r;
    mt_nxt   = mt_r;
    mf_nxt   = mf_r;
    if (!item.is_empty) begin
      if ((cnt_r >= tfv_pkg::LENGTH_BITS'(4)) ||
          (item.ch != tfv_pkg::true_char(cnt_r[1:0]))) begin
        mt_nxt = 1'b0;
      end
      if ((cnt_r >= tfv_pkg::LENGTH_BITS'(5)) ||
          (item.ch != tfv_pkg::false_char(cnt_r[2:0]))) begin
        mf_nxt = 1'b0;
      end
      unique case (item.func)
        tfv_pkg::FUNC_INT: begin
          if (!is_sign && !fail_r) begin
            if (!is_digit || (mag_sum > mag_lim)) begin
              fail_nxt = 1'b1;
            end else begin
              mag_nxt = mag_sum[tfv_pkg::MAG_W-1:0];
            end
          end
        end
        tfv_pkg::FUNC_FLOAT: begin
          if (!is_sign && !is_digit) begin
            if (item.ch == tfv_pkg::CH_DOT) begin
              if (dot_r) begin
                fail_nxt = 1'b1;
              end
              dot_nxt = 1'b1;
            end else begin
              fail_nxt = 1'b1;
            end
          end
        end
        tfv_pkg::FUNC_STRING, tfv_pkg::FUNC_BOOL: begin
        end
        default: begin
        end
      endcase
      if (is_digit) begin
        dig_nxt = 1'b1;
      end
      if (cnt_r != tfv_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + tfv_pkg::LENGTH_BITS'(1);
      end
    end
  end

  // Judge the value under the type of this request
  always_comb begin
    unique case (item.func)
      tfv_pkg::FUNC_INT, tfv_pkg::FUNC_FLOAT: verdict = !fail_nxt && dig_nxt;
      tfv_pkg::FUNC_STRING:
        verdict = (tfv_pkg::CMP_W'(cnt_nxt) <= tfv_pkg::CMP_W'(item.max_length));
      tfv_pkg::FUNC_BOOL:
        verdict = ((cnt_nxt == tfv_pkg::LENGTH_BITS'(4)) && mt_nxt) ||
                  ((cnt_nxt == tfv_pkg::LENGTH_BITS'(5)) && mf_nxt);
      default: verdict = 1'b0;
    endcase
  end

  // Advance the state, clear it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.last)) begin
      cnt_r  <= '0;
      mag_r  <= '0;
      neg_r  <= 1'b0;
      fail_r <= 1'b0;
      dot_r  <= 1'b0;
      dig_r  <= 1'b0;
      mt_r   <= 1'b1;
      mf_r   <= 1'b1;
    end else if (fire) begin
      cnt_r  <= cnt_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      fail_r <= fail_nxt;
      dot_r  <= dot_nxt;
      dig_r  <= dig_nxt;
      mt_r   <= mt_nxt;
      mf_r   <= mf_nxt;
    end
  end

  // The field state is fresh after every verdict
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.last |=> (cnt_r == '0) && (mag_r == '0) && !fail_r && mt_r && mf_r)
    else $error("field state not cleared after last request");

  // Without a request the state holds
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cnt_r) && $stable(mag_r) && $stable(fail_r))
    else $error("field state moved without a request");

  // The magnitude never leaves the signed 32-bit range
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= tfv_pkg::INT_NEG_LIM[tfv_pkg::MAG_W-1:0])
    else $error("magnitude beyond signed 32-bit range");

endmodule

// File: hdl/tfv_out_reg.sv
// Result register holding one verdict until the receiver takes it.
module tfv_out_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       verdict,
  output logic       busy,
  tfv_out_if.source  out_chan
);

  logic valid_r;
  logic res_r;

  // Hold the verdict until taken; a new one may replace it on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= verdict;
    end
  end

  assign busy               = valid_r && !out_chan.ready;
  assign out_chan.valid     = valid_r;
  assign out_chan.valid_res = res_r;

endmodule

// File: hdl/typed_field_text_validator_unit.sv
// Top level of the typed field text validator.
//
// A field value streams in on in_chan, one character request per cycle,
// each with its column type, the string length limit, an empty flag and a
// last flag. A lone request with is_empty set and last set stands for an
// empty value. On each request marked last one verdict leaves on out_chan:
// valid_res is 1 when the whole value passes the check for the type given
// with that last request (int, float, string length, or bool "true"/"false").
// Requests without last produce no result.
// Throughput: one request per cycle, sustained unless a held verdict stalls a
// last request, set by the single check stage (a times-ten shift-add on the
// 32-bit magnitude plus flag updates). A verdict leaves through the input
// register, which holds the last request, and then the result register,
// which loads the verdict when that request drains from the input register.
// Reset (rst_n low, synchronous) empties both registers and clears the
// field state. When the receiver stalls the verdict is held; character
// requests without last keep flowing, and a last request waits in the
// input register until the held verdict is taken.
module typed_field_text_validator_unit (
  input  logic       clk,
  input  logic       rst_n,
  tfv_in_if.sink     in_chan,
  tfv_out_if.source  out_chan
);

  tfv_pkg::stage_t stage;
  logic            out_busy;
  logic            advance;
  logic            load;
  logic            verdict;

  // Drain the input stage unless a verdict would overwrite a stalled one
  assign advance = stage.valid && (!stage.item.last || !out_busy);
  assign load    = advance && stage.item.last;

  tfv_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  tfv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (stage.item),
    .fire    (advance),
    .verdict (verdict)
  );

  tfv_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .verdict  (verdict),
    .busy     (out_busy),
    .out_chan (out_chan)
  );

  // A held verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !load)
    else $error("verdict overwritten while stalled");

  // A stalled input stage takes no new request
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !advance |-> !in_chan.ready)
    else $error("request accepted into a stalled stage");

  // Every loaded verdict shows up on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_chan.valid)
    else $error("loaded verdict not presented");

endmodule
